// ----- hdl/growing_stack_allocator_defines.svh -----
`ifndef GROWING_STACK_ALLOCATOR_DEFINES_SVH
`define GROWING_STACK_ALLOCATOR_DEFINES_SVH

// Assertion helpers for the stack allocator. They expect signals named clk and
// rst in the module that uses them.

// The consequent must hold in the same cycle as the antecedent.
`define GSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gsa_pkg.sv -----
package gsa_pkg;

  // Default values of the top level parameters.
  localparam int ADDR_BITS_DEF    = 32;
  localparam int STACK_DEPTH_DEF  = 64;
  localparam int HEADER_BYTES_DEF = 8;

  // Fixed widths of the ports.
  localparam int FIELD_W = 32;
  localparam int LOG_W   = 5;
  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_PURGE = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_ORDER  = 2'd2,
    ST_DEPTH  = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_flags_t;

  // Width of the unwrapped sums (block end, grown commit end). Wide enough that
  // no carry is lost, but never past 64 bits where the address itself wraps.
  function automatic int ext_bits(input int addr_bits);
    int w;
    w = addr_bits + 2;
    if (w < 35) w = 35;
    if (w > 64) w = 64;
    return w;
  endfunction

endpackage

// ----- hdl/gsa_cfg.sv -----
module gsa_cfg import gsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [FIELD_W-1:0] pwdata,
  output logic [FIELD_W-1:0] prdata,
  output logic               pready,
  output logic [FIELD_W-1:0] region_base,
  output logic [FIELD_W-1:0] region_size,
  output logic [LOG_W-1:0]   grain_log2
);

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_GRAIN = 2'd2;

  localparam logic [LOG_W-1:0] GRAIN_RESET = LOG_W'(16);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_size <= '0;
      grain_log2  <= GRAIN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE:  region_base <= pwdata;
        REG_SIZE:  region_size <= pwdata;
        REG_GRAIN: grain_log2  <= pwdata[LOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE:  prdata = region_base;
      REG_SIZE:  prdata = region_size;
      REG_GRAIN: prdata = FIELD_W'(grain_log2);
      default:   prdata = '0;
    endcase
  end

endmodule

// ----- hdl/gsa_prep.sv -----
module gsa_prep import gsa_pkg::*; #(
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_fire,
  input  logic                                advance,
  input  logic [1:0]                          kind,
  input  logic [FIELD_W-1:0]                  req_size,
  input  logic [LOG_W-1:0]                    align_log2,
  input  logic [FIELD_W-1:0]                  align_offset,
  input  logic [FIELD_W-1:0]                  free_addr,
  input  logic [FIELD_W-1:0]                  region_base,
  input  logic [LOG_W-1:0]                    grain_log2,
  output logic                                s1_valid,
  output kind_t                               s1_kind,
  output logic [ADDR_BITS-1:0]                s1_neg_bias,
  output logic [ADDR_BITS-1:0]                s1_align_mask,
  output logic [ext_bits(ADDR_BITS)-1:0]      s1_total,
  output logic [ext_bits(ADDR_BITS)-1:0]      s1_need,
  output logic [FIELD_W-1:0]                  s1_free_addr
);

  localparam int EXT = ext_bits(ADDR_BITS);

  logic [ADDR_BITS-1:0] base_a;
  logic [ADDR_BITS-1:0] off_a;
  logic [ADDR_BITS-1:0] hdr_a;
  logic [ADDR_BITS-1:0] neg_bias;
  logic [ADDR_BITS-1:0] align_mask;
  logic [EXT-1:0]       total;
  logic [EXT-1:0]       grain_mask;
  logic [EXT-1:0]       need;

  // Everything here is independent of the allocator state, so it is worked
  // out ahead of the state update.
  assign base_a     = ADDR_BITS'(region_base);
  assign off_a      = ADDR_BITS'(align_offset);
  assign hdr_a      = ADDR_BITS'(HEADER_BYTES);
  assign neg_bias   = -(base_a + off_a + hdr_a);
  assign align_mask = ~({ADDR_BITS{1'b1}} << align_log2);
  assign total      = EXT'(req_size) + EXT'(HEADER_BYTES);
  assign grain_mask = ~({EXT{1'b1}} << grain_log2);
  assign need       = (total + grain_mask) & ~grain_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind       <= kind_t'(kind);
      s1_neg_bias   <= neg_bias;
      s1_align_mask <= align_mask;
      s1_total      <= total;
      s1_need       <= need;
      s1_free_addr  <= free_addr;
    end
  end

endmodule

// ----- hdl/gsa_stack.sv -----
`include "growing_stack_allocator_defines.svh"

module gsa_stack import gsa_pkg::*; #(
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stack_op_t            op,
  input  logic [ADDR_BITS-1:0] push_top,
  input  logic [ADDR_BITS-1:0] push_addr,
  output stack_flags_t         flags,
  output logic [ADDR_BITS-1:0] top_saved,
  output logic [ADDR_BITS-1:0] top_issued
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]        live_count;
  logic [CW-1:0]        live_count_next;
  logic [IW-1:0]        wr_idx;
  logic [IW-1:0]        rd_idx;
  logic [ADDR_BITS-1:0] saved_mem  [STACK_DEPTH];
  logic [ADDR_BITS-1:0] issued_mem [STACK_DEPTH];

  always_comb begin
    live_count_next = live_count;
    if (op.push) begin
      live_count_next = live_count + 1'b1;
    end else if (op.pop) begin
      live_count_next = live_count - 1'b1;
    end
  end

  assign wr_idx      = live_count[IW-1:0];
  assign rd_idx      = IW'(live_count_next - 1'b1);
  assign flags.full  = (live_count == CW'(STACK_DEPTH));
  assign flags.empty = (live_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else begin
      live_count <= live_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      saved_mem[wr_idx]  <= push_top;
      issued_mem[wr_idx] <= push_addr;
    end
  end

  // The newest entry is kept in registers, read ahead at the next count. A push
  // writes the very entry that becomes the newest, so it is forwarded.
  always_ff @(posedge clk) begin
    if (op.push) begin
      top_saved  <= push_top;
      top_issued <= push_addr;
    end else begin
      top_saved  <= saved_mem[rd_idx];
      top_issued <= issued_mem[rd_idx];
    end
  end

  `GSA_ASSERT_NOW(a_push_not_full, op.push, !flags.full, "push into a full stack")
  `GSA_ASSERT_NOW(a_pop_not_empty, op.pop, !flags.empty, "pop from an empty stack")
  `GSA_ASSERT_NEXT(a_push_count, op.push, live_count == CW'($past(live_count) + 1'b1), "count did not grow on push")
  `GSA_ASSERT_NEXT(a_push_forward, op.push, top_issued == $past(push_addr), "newest entry not forwarded")

endmodule

// ----- hdl/gsa_core.sv -----
module gsa_core import gsa_pkg::*; #(
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic                           rsp_ready,
  input  kind_t                          s1_kind,
  input  logic [ADDR_BITS-1:0]           s1_neg_bias,
  input  logic [ADDR_BITS-1:0]           s1_align_mask,
  input  logic [ext_bits(ADDR_BITS)-1:0] s1_total,
  input  logic [ext_bits(ADDR_BITS)-1:0] s1_need,
  input  logic [FIELD_W-1:0]             s1_free_addr,
  input  logic [FIELD_W-1:0]             region_base,
  input  logic [FIELD_W-1:0]             region_size,
  input  logic [LOG_W-1:0]               grain_log2,
  input  stack_flags_t                   flags,
  input  logic [ADDR_BITS-1:0]           top_saved,
  input  logic [ADDR_BITS-1:0]           top_issued,
  output stack_op_t                      op,
  output logic [ADDR_BITS-1:0]           push_top,
  output logic [ADDR_BITS-1:0]           push_addr,
  output logic                           rsp_valid,
  output logic [FIELD_W-1:0]             user_addr,
  output logic [1:0]                     status,
  output logic [FIELD_W-1:0]             committed_bytes,
  output logic [FIELD_W-1:0]             used_bytes
);

  localparam int EXT = ext_bits(ADDR_BITS);

  logic [ADDR_BITS-1:0] top_offset;
  logic [ADDR_BITS-1:0] top_offset_next;
  logic [ADDR_BITS-1:0] committed_end;
  logic [ADDR_BITS-1:0] committed_end_next;

  logic [ADDR_BITS-1:0] base_a;
  logic [ADDR_BITS-1:0] pad;
  logic [ADDR_BITS-1:0] new_top;
  logic [ADDR_BITS-1:0] uaddr;
  logic [EXT-1:0]       block_end;
  logic [EXT-1:0]       grow_sum;
  logic                 grow_ok;
  logic                 passes;
  logic                 beyond;
  logic [ADDR_BITS-1:0] abs_top;
  logic [ADDR_BITS-1:0] grain_mask;
  logic [ADDR_BITS-1:0] purge_end;

  stack_op_t            op_raw;
  status_t              st;
  logic [ADDR_BITS-1:0] ua;

  assign base_a = ADDR_BITS'(region_base);

  // Padding that brings base + top + offset + header up to the alignment.
  assign pad       = (s1_neg_bias - top_offset) & s1_align_mask;
  assign new_top   = top_offset + pad;
  assign uaddr     = base_a + ADDR_BITS'(HEADER_BYTES) + new_top;
  assign block_end = EXT'(new_top) + s1_total;

  // Growth of the committed end does not depend on the new top.
  assign grow_sum = EXT'(committed_end) + s1_need;
  assign grow_ok  = (grow_sum <= EXT'(region_size));
  assign passes   = (block_end > EXT'(committed_end));
  assign beyond   = passes && (!grow_ok || (block_end > grow_sum));

  assign abs_top    = base_a + top_offset;
  assign grain_mask = ~({ADDR_BITS{1'b1}} << grain_log2);
  assign purge_end  = ((abs_top + grain_mask) & ~grain_mask) - base_a;

  always_comb begin
    top_offset_next    = top_offset;
    committed_end_next = committed_end;
    op_raw             = '0;
    st                 = ST_OK;
    ua                 = '0;
    case (s1_kind)
      KIND_ALLOC: begin
        if (flags.full) begin
          st = ST_DEPTH;
        end else begin
          op_raw.push     = 1'b1;
          ua              = uaddr;
          top_offset_next = block_end[ADDR_BITS-1:0];
          if (passes && grow_ok) begin
            committed_end_next = grow_sum[ADDR_BITS-1:0];
          end
          if (beyond) begin
            st = ST_BEYOND;
          end
        end
      end
      KIND_FREE: begin
        if (flags.empty) begin
          st = ST_DEPTH;
        end else if (FIELD_W'(top_issued) != s1_free_addr) begin
          st = ST_ORDER;
        end else begin
          op_raw.pop      = 1'b1;
          top_offset_next = top_saved;
        end
      end
      KIND_PURGE: begin
        committed_end_next = purge_end;
      end
      default: ;
    endcase
  end

  assign op        = fire ? op_raw : '0;
  assign push_top  = top_offset;
  assign push_addr = uaddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_offset    <= '0;
      committed_end <= '0;
    end else if (fire) begin
      top_offset    <= top_offset_next;
      committed_end <= committed_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      user_addr       <= FIELD_W'(ua);
      status          <= st;
      committed_bytes <= FIELD_W'(committed_end_next);
      used_bytes      <= FIELD_W'(top_offset_next);
    end
  end

endmodule

// ----- hdl/growing_stack_allocator.sv -----
// LIFO stack allocator over a reserved address region whose committed part
// grows in steps of a power-of-two granule. Each request beat is an allocate,
// a free, a purge or a no-op, and each one answers with exactly one result
// beat. The block takes one request per clock cycle when the result side
// keeps up. The request register holds the request together with the
// parts that do not depend on the allocator state (header bias, rounded
// growth size, alignment mask). When the request executes, the top and the
// committed end are updated in one step and the result register is loaded,
// so that loop through the top register and the commit register is
// what fixes the rate at one request per cycle. A result register and a
// request register both hold beats, so a new request is accepted while a
// finished result still waits for rsp_ready. The stack of saved tops and
// issued addresses is a memory with one write and one registered read port;
// its newest entry is kept read ahead, so a free checks its pointer without
// waiting. There is no clearing pass after reset: only entries below the live
// count are ever looked at. Configuration registers sit on the APB port at
// byte addresses 0 (region base), 4 (region size) and 8 (log2 of the commit
// granule, reset 16); write them only while no request is in flight.
module growing_stack_allocator import gsa_pkg::*; #(
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [FIELD_W-1:0] pwdata,
  output logic [FIELD_W-1:0] prdata,
  output logic               pready,
  // Request channel.
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         kind,
  input  logic [FIELD_W-1:0] req_size,
  input  logic [LOG_W-1:0]   align_log2,
  input  logic [FIELD_W-1:0] align_offset,
  input  logic [FIELD_W-1:0] free_addr,
  // Result channel.
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [FIELD_W-1:0] user_addr,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] committed_bytes,
  output logic [FIELD_W-1:0] used_bytes
);

  localparam int EXT = ext_bits(ADDR_BITS);

  logic [FIELD_W-1:0]   region_base;
  logic [FIELD_W-1:0]   region_size;
  logic [LOG_W-1:0]     grain_log2;

  logic                 s1_valid;
  kind_t                s1_kind;
  logic [ADDR_BITS-1:0] s1_neg_bias;
  logic [ADDR_BITS-1:0] s1_align_mask;
  logic [EXT-1:0]       s1_total;
  logic [EXT-1:0]       s1_need;
  logic [FIELD_W-1:0]   s1_free_addr;

  stack_op_t            op;
  stack_flags_t         flags;
  logic [ADDR_BITS-1:0] push_top;
  logic [ADDR_BITS-1:0] push_addr;
  logic [ADDR_BITS-1:0] top_saved;
  logic [ADDR_BITS-1:0] top_issued;

  logic                 fire;
  logic                 in_fire;

  // A registered request executes whenever the result register is empty or
  // is being emptied in this cycle. The request register then frees up, so a
  // new beat can be taken in the same cycle.
  assign fire      = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || fire;
  assign in_fire   = req_valid && req_ready;

  gsa_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_base (region_base),
    .region_size (region_size),
    .grain_log2  (grain_log2)
  );

  gsa_prep #(
    .ADDR_BITS    (ADDR_BITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .advance       (fire),
    .kind          (kind),
    .req_size      (req_size),
    .align_log2    (align_log2),
    .align_offset  (align_offset),
    .free_addr     (free_addr),
    .region_base   (region_base),
    .grain_log2    (grain_log2),
    .s1_valid      (s1_valid),
    .s1_kind       (s1_kind),
    .s1_neg_bias   (s1_neg_bias),
    .s1_align_mask (s1_align_mask),
    .s1_total      (s1_total),
    .s1_need       (s1_need),
    .s1_free_addr  (s1_free_addr)
  );

  gsa_stack #(
    .ADDR_BITS   (ADDR_BITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .push_top   (push_top),
    .push_addr  (push_addr),
    .flags      (flags),
    .top_saved  (top_saved),
    .top_issued (top_issued)
  );

  gsa_core #(
    .ADDR_BITS    (ADDR_BITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .rsp_ready       (rsp_ready),
    .s1_kind         (s1_kind),
    .s1_neg_bias     (s1_neg_bias),
    .s1_align_mask   (s1_align_mask),
    .s1_total        (s1_total),
    .s1_need         (s1_need),
    .s1_free_addr    (s1_free_addr),
    .region_base     (region_base),
    .region_size     (region_size),
    .grain_log2      (grain_log2),
    .flags           (flags),
    .top_saved       (top_saved),
    .top_issued      (top_issued),
    .op              (op),
    .push_top        (push_top),
    .push_addr       (push_addr),
    .rsp_valid       (rsp_valid),
    .user_addr       (user_addr),
    .status          (status),
    .committed_bytes (committed_bytes),
    .used_bytes      (used_bytes)
  );

endmodule
